/* src/lsac_pkg.sv */
`timescale 1ns / 1ps
package lsac_pkg;
   typedef struct packed {
      logic rd_demand;
      logic rd_next;
      logic wr_demand;
      logic wr_next;
      logic clear;
      logic capture;
      logic load;
   } cmd_type;

   localparam logic [1:0] MODE_ALLOC    = 2'd0;
   localparam logic [1:0] MODE_NOALLOC  = 2'd1;
   localparam logic [1:0] MODE_PREFETCH = 2'd2;
   localparam logic [1:0] MODE_PF_MISS  = 2'd3;
   localparam logic [63:0] NEXT_STRIDE  = 64'd32;
endpackage

/* src/lsac_if.sv */
`timescale 1ns / 1ps
interface lsac_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] address;
   logic        is_store;
   logic [30:0] access_time;
   modport source (output valid, address, is_store, access_time, input ready);
   modport sink (input valid, address, is_store, access_time, output ready);
endinterface

interface lsac_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        next_line_present;
   logic [31:0] hit_count;
   logic [31:0] access_count;
   modport source (output valid, hit, next_line_present, hit_count, access_count,
      input ready);
   modport sink (input valid, hit, next_line_present, hit_count, access_count,
      output ready);
endinterface

interface lsac_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/lsac_ram.sv */
`timescale 1ns / 1ps
module lsac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/lsac_datapath.sv */
`timescale 1ns / 1ps
module lsac_datapath #(
   parameter int SETS = 128,
   parameter int WAYS = 4,
   parameter int OFFB = 5
) (
   input  logic              clock,
   input  lsac_pkg::cmd_type cmd,
   input  logic [63:0]       address,
   input  logic              is_store,
   input  logic [30:0]       access_time,
   input  logic [1:0]        mode,
   output logic              hit,
   output logic              next_line_present
);
   localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int LB = (SETS > 1) ? $clog2(SETS) : 0;
   localparam int TW = 64 - OFFB - LB;
   localparam int LW = 1 + TW + 32;
   localparam int RW = WAYS * LW;
   localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RD = (SETS > 1) ? SETS : 2;

   logic [63:0]      addr2;
   logic [63-OFFB:0] blk1, blk2;
   logic [SB-1:0]    set1, set2, clr_ff, clr_in, rd_addr, wr_addr;
   logic [TW-1:0]    tag1, tag2;
   logic [RW-1:0]    rd_data, wr_data, rowh_ff, rowh_in;
   logic             wr_en;
   logic [31:0]      t, t1;
   logic             h_ff, h_in, p_ff, p_in;
   logic [IW-1:0]    i1, i2, i1_ff, i1_in;
   logic [RW-1:0]    row1_hit, row1_new, row2_src, row2_hit, row2_mid, row2_new;
   logic             f1, f2, pf, alloc1, do2, same;

   assign t = {1'b0, access_time};
   assign t1 = t + 32'd1;
   assign addr2 = address + lsac_pkg::NEXT_STRIDE;
   assign blk1 = address[63:OFFB];
   assign blk2 = addr2[63:OFFB];
   assign set1 = (SETS > 1) ? SB'(blk1) : '0;
   assign set2 = (SETS > 1) ? SB'(blk2) : '0;
   assign tag1 = TW'(blk1 >> LB);
   assign tag2 = TW'(blk2 >> LB);

   function automatic logic [IW-1:0] scan(input logic [RW-1:0] row,
         input logic [TW-1:0] tg, input logic [31:0] thr, output logic found);
      logic [31:0]   best;
      logic [IW-1:0] sel;
      logic          v;
      logic [TW-1:0] rt;
      logic [31:0]   rtm;
      best = thr; sel = '0; found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         v   = row[w*LW + TW + 32];
         rt  = row[w*LW + 32 +: TW];
         rtm = row[w*LW +: 32];
         if (!found) begin
            if (v && rt == tg) begin
               found = 1'b1;
               sel = IW'(w);
            end else if ((rtm ^ 32'h8000_0000) < (best ^ 32'h8000_0000)) begin
               sel = IW'(w); best = rtm;
            end
         end
      end
      return sel;
   endfunction

   function automatic logic [RW-1:0] set_time(input logic [RW-1:0] row,
         input logic [IW-1:0] w, input logic [31:0] tm);
      logic [RW-1:0] r;
      r = row;
      r[w*LW +: 32] = tm;
      return r;
   endfunction

   function automatic logic [RW-1:0] fill_way(input logic [RW-1:0] row,
         input logic [IW-1:0] w, input logic [TW-1:0] tg, input logic [31:0] tm);
      logic [RW-1:0] r;
      r = row;
      r[w*LW +: LW] = {1'b1, tg, tm};
      return r;
   endfunction

   always_comb begin
      pf = mode[1];
      alloc1 = !(mode == lsac_pkg::MODE_NOALLOC && is_store);
      i1 = scan(rd_data, tag1, pf ? t1 : t, f1);
      row1_hit = f1 ? set_time(rd_data, i1, t) : rd_data;
      row1_new = (!f1 && alloc1) ? fill_way(row1_hit, i1, tag1, t) : row1_hit;
      do2 = pf && !(mode == lsac_pkg::MODE_PF_MISS && h_ff);
      same = (set1 == set2);
      row2_src = same ? rowh_ff : rd_data;
      i2 = scan(row2_src, tag2, t, f2);
      row2_hit = (f2 && do2) ? set_time(row2_src, i2, t1) : row2_src;
      row2_mid = (same && !h_ff && alloc1) ? fill_way(row2_hit, i1_ff, tag1, t) : row2_hit;
      row2_new = (do2 && !f2) ? fill_way(row2_mid, i2, tag2, t1) : row2_mid;
   end

   assign rd_addr = cmd.rd_next ? set2 : set1;
   assign clr_in = clr_ff + 1'b1;
   assign h_in = cmd.rd_demand ? f1 : h_ff;
   assign p_in = cmd.wr_next ? (f2 && do2) : (cmd.rd_demand ? 1'b0 : p_ff);
   assign rowh_in = cmd.rd_demand ? row1_hit : rowh_ff;
   assign i1_in = cmd.rd_demand ? i1 : i1_ff;

   always_comb begin
      wr_en = cmd.clear | cmd.wr_demand | cmd.wr_next;
      wr_addr = cmd.clear ? clr_ff : (cmd.wr_next ? set2 : set1);
      wr_data = cmd.clear ? {WAYS{1'b0, {TW{1'b0}}, 32'hFFFF_FFFF}} :
                (cmd.wr_next ? row2_new : row1_new);
   end

   always_ff @(posedge clock) begin
      clr_ff <= cmd.clear ? clr_in : '0;
      h_ff <= h_in;
      p_ff <= p_in;
      rowh_ff <= rowh_in;
      i1_ff <= i1_in;
   end

   assign hit = h_ff;
   assign next_line_present = p_ff;

   lsac_ram #(.WIDTH(RW), .DEPTH(RD)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));
endmodule

/* src/lsac_ctrl.sv */
`timescale 1ns / 1ps
module lsac_ctrl #(
   parameter int SETS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   output lsac_pkg::cmd_type cmd,
   output logic              count_en
);
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_RD1 = 6'b000100,
      S_RD2 = 6'b001000, S_WR2 = 6'b010000, S_OUT = 6'b100000
   } state_type;
   localparam int CW = $clog2(SETS + 1);
   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      count_en = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.rd_next = 1'b0;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd_demand = 1'b1;
            cmd.wr_demand = 1'b1;
            cmd.rd_next = 1'b1;
            state_in = S_WR2;
         end
         S_WR2: begin
            cmd.wr_next = 1'b1;
            count_en = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            req_ready = out_free;
            if (out_free) begin
               cmd.load = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in = S_RD1;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* src/lru_set_assoc_cache_model_unit.sv */
`timescale 1ns / 1ps
// Set-associative cache model with timestamp LRU and next-line prefetch.
// Channels: req (address, is_store, access_time) in, rsp (hit,
// next_line_present, hit_count, access_count) out, csr sets policy_mode.
// All use valid/ready; an item moves when both are high.
// After reset the block sweeps the set RAM, one set a cycle (SETS sets,
// 128 by default), clearing valid bits and setting times to all ones; req
// is held off meanwhile. Counters and policy_mode clear to zero.
// Each item steps through demand set read, demand lookup and write with
// next-line read, next-line lookup and write; then the result loads into
// the rsp register, which raises rsp valid. While busy, the block takes a
// new item only in the cycle the result loads, so items do not overlap.
// When rsp stalls, the result holds in the rsp register; the next item
// runs its lookups and then waits, with req held off, until it frees.
// Write csr only while idle.
module lru_set_assoc_cache_model_unit #(
   parameter int CACHE_BYTES = 16384,
   parameter int LINE_BYTES  = 32,
   parameter int WAYS        = 4
) (
   input logic clock,
   input logic reset,
   lsac_req_if.sink   req,
   lsac_rsp_if.source rsp,
   lsac_csr_if.sink   csr
);
   localparam int SETS0 = CACHE_BYTES / LINE_BYTES / WAYS;
   localparam int SETS  = (SETS0 > 0) ? (1 << $clog2(SETS0 + 1) >> 1) : 1;
   localparam int OFFB  = $clog2(LINE_BYTES + 1) - 1;

   lsac_pkg::cmd_type cmd;
   logic        count_en, hit, next_hit, out_free;
   logic [1:0]  mode_ff;
   logic [63:0] addr_ff;
   logic        st_ff;
   logic [30:0] t_ff;
   logic [31:0] hc_ff, ac_ff;
   logic        vld_ff, hit_ff, np_ff;
   logic [31:0] hc_out_ff, ac_out_ff;

   assign csr.ready = 1'b1;
   assign out_free = !vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lsac_pkg::MODE_ALLOC;
         hc_ff <= '0;
         ac_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (csr.valid) mode_ff <= csr.data;
         if (count_en) begin
            ac_ff <= ac_ff + 32'd1;
            if (hit) hc_ff <= hc_ff + 32'd1;
         end
         if (cmd.load) vld_ff <= 1'b1;
         else if (rsp.ready) vld_ff <= 1'b0;
      end
      if (cmd.capture) begin
         addr_ff <= req.address;
         st_ff <= req.is_store;
         t_ff <= req.access_time;
      end
      if (cmd.load) begin
         hit_ff <= hit;
         np_ff <= next_hit;
         hc_out_ff <= hc_ff;
         ac_out_ff <= ac_ff;
      end
   end

   lsac_ctrl #(.SETS(SETS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .out_free(out_free), .cmd(cmd), .count_en(count_en));

   lsac_datapath #(.SETS(SETS), .WAYS(WAYS), .OFFB(OFFB)) u_dp (
      .clock(clock), .cmd(cmd), .address(addr_ff), .is_store(st_ff),
      .access_time(t_ff), .mode(mode_ff), .hit(hit),
      .next_line_present(next_hit));

   assign rsp.valid = vld_ff;
   assign rsp.hit = hit_ff;
   assign rsp.next_line_present = np_ff;
   assign rsp.hit_count = hc_out_ff;
   assign rsp.access_count = ac_out_ff;
endmodule

/* sim/lru_set_assoc_cache_model_unit_tb.sv */
`timescale 1ns / 1ps
module lru_set_assoc_cache_model_unit_tb;
   localparam int SETS = 128;
   localparam int WAYS = 4;
   localparam int NLINES = SETS * WAYS;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        hit;
      logic        next_present;
      logic [31:0] hit_count;
      logic [31:0] access_count;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsac_req_if req_ch();
   lsac_rsp_if rsp_ch();
   lsac_csr_if csr_ch();

   lru_set_assoc_cache_model_unit u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   bit          tag_valid [NLINES];
   logic [51:0] tag_store [NLINES];
   logic [31:0] use_time [NLINES];
   logic [31:0] hits_seen;
   logic [31:0] accesses_seen;
   logic [1:0]  mode;

   lookup_type lookups_due[$];
   int      mismatches = 0;
   longint  cycles = 0;
   logic [63:0] hot_addr [8];

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic bit older(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic lookup_type predict_lookup(logic [63:0] addr, bit store,
         logic [30:0] at);
      logic [31:0] t;
      logic [31:0] t1;
      logic [31:0] best1;
      logic [31:0] best2;
      logic [63:0] addr2;
      int base1;
      int base2;
      int lr1;
      int lr2;
      bit h;
      bit p;
      logic [51:0] tag1;
      logic [51:0] tag2;
      lookup_type r;
      t = {1'b0, at};
      t1 = t + 32'd1;
      h = 0;
      p = 0;
      lr1 = 0;
      lr2 = 0;
      addr2 = addr + lsac_pkg::NEXT_STRIDE;
      base1 = int'(addr[11:5]) * WAYS;
      base2 = int'(addr2[11:5]) * WAYS;
      tag1 = addr[63:12];
      tag2 = addr2[63:12];
      accesses_seen = accesses_seen + 32'd1;
      if (mode == lsac_pkg::MODE_ALLOC || mode == lsac_pkg::MODE_NOALLOC) begin
         best1 = t;
         for (int s = 0; s < WAYS; s++) begin
            if (tag_valid[base1 + s] && tag_store[base1 + s] == tag1) begin
               h = 1;
               use_time[base1 + s] = t;
               break;
            end else if (older(use_time[base1 + s], best1)) begin
               lr1 = s;
               best1 = use_time[base1 + s];
            end
         end
         if (!h && !(mode == lsac_pkg::MODE_NOALLOC && store)) begin
            tag_valid[base1 + lr1] = 1;
            tag_store[base1 + lr1] = tag1;
            use_time[base1 + lr1] = t;
         end
      end else begin
         best1 = t1;
         for (int s = 0; s < WAYS && !h; s++) begin
            if (tag_valid[base1 + s] && tag_store[base1 + s] == tag1) begin
               h = 1;
               use_time[base1 + s] = t;
            end else if (older(use_time[base1 + s], best1)) begin
               lr1 = s;
               best1 = use_time[base1 + s];
            end
         end
         best2 = t;
         if (!(mode == lsac_pkg::MODE_PF_MISS && h)) begin
            for (int s = 0; s < WAYS && !p; s++) begin
               if (tag_valid[base2 + s] && tag_store[base2 + s] == tag2) begin
                  use_time[base2 + s] = t1;
                  p = 1;
               end else if (older(use_time[base2 + s], best2)) begin
                  lr2 = s;
                  best2 = use_time[base2 + s];
               end
            end
         end
         if (!h) begin
            tag_valid[base1 + lr1] = 1;
            tag_store[base1 + lr1] = tag1;
            use_time[base1 + lr1] = t;
         end
         if (!p && (!h || mode == lsac_pkg::MODE_PREFETCH)) begin
            tag_valid[base2 + lr2] = 1;
            tag_store[base2 + lr2] = tag2;
            use_time[base2 + lr2] = t1;
         end
      end
      if (h) hits_seen = hits_seen + 32'd1;
      r.hit = h;
      r.next_present = p;
      r.hit_count = hits_seen;
      r.access_count = accesses_seen;
      return r;
   endfunction

   // result checker with random stall
   int rsp_wait = 0;
   always @(posedge clock) begin
      lookup_type got;
      lookup_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.hit, rsp_ch.next_line_present, rsp_ch.hit_count,
               rsp_ch.access_count};
            if (lookups_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item %h", got);
            end else begin
               want = lookups_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp hit=%b np=%b hc=%0d ac=%0d",
                        want.hit, want.next_present, want.hit_count, want.access_count,
                        " got hit=%b np=%b hc=%0d ac=%0d",
                        got.hit, got.next_present, got.hit_count, got.access_count);
               end
            end
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 2) == 0) rsp_wait = 0;
            rsp_ch.ready <= (rsp_wait == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= (rsp_wait == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_access(logic [63:0] addr, bit store, logic [30:0] at);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.address <= addr;
      req_ch.is_store <= store;
      req_ch.access_time <= at;
      do @(posedge clock); while (!req_ch.ready);
      lookups_due.insert(lookups_due.size(), predict_lookup(addr, store, at));
   endtask

   task automatic set_mode(logic [1:0] m);
      req_ch.valid <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= m;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      mode = m;
   endtask

   logic [30:0] clock_now = 31'd100;

   function automatic logic [63:0] pick_addr();
      logic [63:0] a;
      case ($urandom_range(0, 3))
         0: a = {$urandom, $urandom};
         1: a = hot_addr[$urandom_range(0, 7)];
         2: a = hot_addr[$urandom_range(0, 7)] + 64'd32;
         default: a = {32'h0, 16'h0, 4'($urandom_range(0, 15)), 12'h0}
            | {52'h0, 7'd3, 5'($urandom)};
      endcase
      return a;
   endfunction

   task automatic test_directed_extremes();
      send_access(64'h0, 1'b0, 31'd0);
      send_access(64'h0, 1'b1, 31'd1);
      send_access(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 31'h7FFF_FFFF);
      send_access(64'hFFFF_FFFF_FFFF_FFE0, 1'b0, 31'h7FFF_FFFE);
      for (int i = 0; i < 6; i++)
         send_access({52'(i), 12'h060}, 1'b0, 31'(10 + i));
      send_access(64'h0000_0000_0000_1060, 1'b0, 31'd20);
   endtask

   task automatic test_policy(logic [1:0] m, int n);
      set_mode(m);
      send_access(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 31'h7FFF_FFFF);
      send_access(64'h0000_0000_0000_5000, 1'b1, 31'd5);
      send_access(64'h0000_0000_0000_5000, 1'b0, 31'd6);
      send_access(64'h0000_0000_0000_4FE0, 1'b0, 31'd7);
      for (int i = 0; i < n; i++) begin
         clock_now = clock_now + 31'($urandom_range(0, 3));
         if ($urandom_range(0, 40) == 0) clock_now = 31'($urandom);
         send_access(pick_addr(), 1'($urandom), clock_now);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.address = '0;
      req_ch.is_store = 1'b0;
      req_ch.access_time = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      mode = lsac_pkg::MODE_ALLOC;
      hits_seen = '0;
      accesses_seen = '0;
      for (int i = 0; i < NLINES; i++) begin
         tag_valid[i] = 0;
         tag_store[i] = '0;
         use_time[i] = '1;
      end
      for (int i = 0; i < 8; i++) hot_addr[i] = {$urandom, $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_policy(lsac_pkg::MODE_NOALLOC, 130);
      test_policy(lsac_pkg::MODE_PREFETCH, 130);
      test_policy(lsac_pkg::MODE_PF_MISS, 130);
      test_policy(lsac_pkg::MODE_ALLOC, 130);
      req_ch.valid <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
